[src/erdt_pkg.sv]
// Shared types and constants of the event ring dequeue tracker.
// No dependencies; every other file of the block but erdt_ram imports it.
package erdt_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned TRB_SHIFT = 4;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW = $clog2(QDEPTH);

  localparam logic [ADDR_W-1:0] BUSY_FLAG = 64'h8;
  localparam logic [ADDR_W-1:0] BASE_MASK = ~64'hF;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_CONSUME = 2'd1;
  localparam logic [1:0] OP_RESET   = 2'd2;

  typedef enum logic [2:0] {
    K_IGNORE,
    K_LOAD,
    K_CONSUME,
    K_RESET,
    K_NOP
  } kind_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EXEC
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        intr;
    logic [1:0]        seg;
    logic [ADDR_W-1:0] base;
    logic              cyc;
  } cmd_t;

  typedef struct packed {
    logic              consumed;
    logic [ADDR_W-1:0] event_addr;
    logic [ADDR_W-1:0] next_addr;
    logic [ADDR_W-1:0] dequeue_ptr_value;
    logic              cycle_state;
  } res_t;

endpackage

[src/erdt_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module erdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                      rdata_a_o,
  output logic [WIDTH-1:0]                      rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[src/erdt_front.sv]
// Front end: accepts request beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on erdt_pkg.
module erdt_front import erdt_pkg::*; #(
  parameter int SEGMENTS     = 4,
  parameter int INTERRUPTERS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          opcode_i,
  input  logic [1:0]          interrupter_i,
  input  logic [1:0]          segment_i,
  input  logic [ADDR_W-1:0]   base_addr_i,
  input  logic                trb_cycle_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_take_i
);

  cmd_t           q_mem_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPW:0]   count_q, count_d;
  logic           wr_en;
  logic           rd_en;
  cmd_t           new_cmd;

  always_comb begin
    new_cmd.intr = interrupter_i;
    new_cmd.seg  = segment_i;
    new_cmd.base = base_addr_i & BASE_MASK;
    new_cmd.cyc  = trb_cycle_i;
    if (32'(interrupter_i) >= 32'(INTERRUPTERS)) begin
      new_cmd.kind = K_IGNORE;
    end else begin
      case (opcode_i)
        OP_LOAD: begin
          new_cmd.kind = (32'(segment_i) < 32'(SEGMENTS)) ? K_LOAD : K_NOP;
        end
        OP_CONSUME: begin
          new_cmd.kind = K_CONSUME;
        end
        OP_RESET: begin
          new_cmd.kind = K_RESET;
        end
        default: begin
          new_cmd.kind = K_NOP;
        end
      endcase
    end
  end

  assign full_o      = (count_q == (QPW+1)'(QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

[src/erdt_back.sv]
// Back end: per-interrupter ring state, segment base RAM and result register.
// Depends on erdt_pkg and erdt_ram.
module erdt_back import erdt_pkg::*; #(
  parameter int ENTRIES_PER_SEGMENT = 256,
  parameter int SEGMENTS            = 4,
  parameter int INTERRUPTERS        = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_take_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  localparam int IW    = (INTERRUPTERS > 1) ? $clog2(INTERRUPTERS) : 1;
  localparam int SW    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int PW    = $clog2(ENTRIES_PER_SEGMENT);
  localparam int DEPTH = INTERRUPTERS * SEGMENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] ram_addr(input int unsigned i, input int unsigned s);
    return AW'(i * 32'(SEGMENTS) + s);
  endfunction

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [PW-1:0]    pos_q [INTERRUPTERS];
  logic [SW-1:0]    seg_q [INTERRUPTERS];
  logic             cyc_q [INTERRUPTERS];
  logic             out_valid_q;
  res_t             res_q, res_d;

  logic             out_free;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr_a;
  logic [AW-1:0]    ram_raddr_b;
  logic [ADDR_W-1:0] base_a;
  logic [ADDR_W-1:0] base_b;

  logic [IW-1:0]    idx;
  logic [PW-1:0]    cur_pos;
  logic [SW-1:0]    cur_seg;
  logic             cur_cyc;
  logic             last_pos;
  logic             last_seg;
  logic [SW-1:0]    nxt_seg;
  logic             hit;
  logic             commit;
  logic [ADDR_W-1:0] addr_cur;
  logic [ADDR_W-1:0] addr_inc;

  assign out_free = !out_valid_q || pop_i;

  assign idx      = (cmd_q.kind == K_IGNORE) ? '0 : IW'(cmd_q.intr);
  assign cur_pos  = pos_q[idx];
  assign cur_seg  = seg_q[idx];
  assign cur_cyc  = cyc_q[idx];
  assign last_pos = (cur_pos == PW'(ENTRIES_PER_SEGMENT - 1));
  assign last_seg = (cur_seg == SW'(SEGMENTS - 1));
  assign nxt_seg  = last_seg ? '0 : cur_seg + SW'(1);
  assign hit      = (cmd_q.kind == K_CONSUME) && (cmd_q.cyc == cur_cyc);

  assign ram_waddr   = ram_addr(32'(cmd_i.intr), 32'(cmd_i.seg));
  assign ram_raddr_a = ram_addr(32'(idx), (cmd_q.kind == K_RESET) ? 32'd0 : 32'(cur_seg));
  assign ram_raddr_b = ram_addr(32'(idx), 32'(nxt_seg));

  erdt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (DEPTH)
  ) u_base_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (cmd_i.base),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (base_a),
    .rdata_b_o (base_b)
  );

  assign addr_cur = base_a + (ADDR_W'(cur_pos) << TRB_SHIFT);
  assign addr_inc = base_a + ((ADDR_W'(cur_pos) + ADDR_W'(1)) << TRB_SHIFT);

  always_comb begin
    res_d = '0;
    case (cmd_q.kind)
      K_IGNORE: begin
        res_d = '0;
      end
      K_RESET: begin
        res_d.next_addr   = base_a;
        res_d.cycle_state = 1'b1;
      end
      K_CONSUME: begin
        if (hit) begin
          res_d.consumed          = 1'b1;
          res_d.event_addr        = addr_cur;
          res_d.next_addr         = last_pos ? base_b : addr_inc;
          res_d.dequeue_ptr_value = (last_pos ? base_b : addr_inc) | BUSY_FLAG;
          res_d.cycle_state       = (last_pos && last_seg) ? ~cur_cyc : cur_cyc;
        end else begin
          res_d.next_addr   = addr_cur;
          res_d.cycle_state = cur_cyc;
        end
      end
      default: begin
        res_d.next_addr   = addr_cur;
        res_d.cycle_state = cur_cyc;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cmd_take_o = 1'b0;
    ram_we     = 1'b0;
    commit     = 1'b0;
    case (state_q)
      B_IDLE: begin
        cmd_take_o = cmd_valid_i;
        ram_we     = cmd_valid_i && (cmd_i.kind == K_LOAD);
        if (cmd_valid_i) begin
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_EXEC;
      end
      B_EXEC: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < INTERRUPTERS; i++) begin
        pos_q[i] <= '0;
        seg_q[i] <= '0;
        cyc_q[i] <= 1'b1;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit && cmd_q.kind == K_RESET) begin
        pos_q[idx] <= '0;
        seg_q[idx] <= '0;
        cyc_q[idx] <= 1'b1;
      end else if (commit && hit) begin
        pos_q[idx] <= last_pos ? '0 : cur_pos + PW'(1);
        if (last_pos) begin
          seg_q[idx] <= nxt_seg;
          if (last_seg) begin
            cyc_q[idx] <= ~cur_cyc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cmd_q <= cmd_i;
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == B_IDLE)
    else $error("base RAM written outside idle");

  a_read_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_READ |=> state_q == B_EXEC)
    else $error("read phase not followed by execute");

  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EXEC && !out_free) |=> state_q == B_EXEC)
    else $error("execute left while result register busy");

  a_rise_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_EXEC))
    else $error("result appeared without execute");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.consumed) |->
      (res_q.event_addr == '0 && res_q.dequeue_ptr_value == '0))
    else $error("address reported without consume");

endmodule

[src/event_ring_dequeue_tracker_top.sv]
// Dequeue tracker for segmented event rings, one ring per interrupter. A
// request beat is taken whenever full is low and parked in a two-entry
// queue; the back end works one request at a time in three steps (take,
// segment base RAM read, state update into the result register) and takes
// no new one before the last is done; the update step stalls while the
// result register is full. A result waits in a one-deep register until
// popped; new requests keep queuing meanwhile. Ring state is ready right
// after reset; segment bases read as undefined until loaded.
// Depends on erdt_pkg, erdt_front, erdt_back and erdt_ram.
module event_ring_dequeue_tracker_top import erdt_pkg::*; #(
  parameter int ENTRIES_PER_SEGMENT = 256,
  parameter int SEGMENTS            = 4,
  parameter int INTERRUPTERS        = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode_i,
  input  logic [1:0]        interrupter_i,
  input  logic [1:0]        segment_i,
  input  logic [ADDR_W-1:0] base_addr_i,
  input  logic              trb_cycle_i,
  output logic              empty,
  input  logic              pop,
  output logic              consumed_o,
  output logic [ADDR_W-1:0] event_addr_o,
  output logic [ADDR_W-1:0] next_addr_o,
  output logic [ADDR_W-1:0] dequeue_ptr_value_o,
  output logic              cycle_state_o
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  erdt_front #(
    .SEGMENTS     (SEGMENTS),
    .INTERRUPTERS (INTERRUPTERS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .opcode_i      (opcode_i),
    .interrupter_i (interrupter_i),
    .segment_i     (segment_i),
    .base_addr_i   (base_addr_i),
    .trb_cycle_i   (trb_cycle_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_take_i    (cmd_take)
  );

  erdt_back #(
    .ENTRIES_PER_SEGMENT (ENTRIES_PER_SEGMENT),
    .SEGMENTS            (SEGMENTS),
    .INTERRUPTERS        (INTERRUPTERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign consumed_o          = res.consumed;
  assign event_addr_o        = res.event_addr;
  assign next_addr_o         = res.next_addr;
  assign dequeue_ptr_value_o = res.dequeue_ptr_value;
  assign cycle_state_o       = res.cycle_state;

endmodule

[dv/tb_event_ring_dequeue_tracker_top.sv]
// Self-checking testbench for event_ring_dequeue_tracker_top: a queued request driver,
// a result monitor and an in-bench ring state predictor.
// Depends on erdt_pkg and the block's RTL.
module tb_event_ring_dequeue_tracker_top import erdt_pkg::*;;

  localparam int ENTRIES  = 256;
  localparam int SEGS     = 4;
  localparam int INTRS    = 4;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int N_RANDOM = 1750;
  localparam int IDLE_PCT = 29;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        intr;
    logic [1:0]        seg;
    logic [ADDR_W-1:0] base;
    logic              cyc;
    logic              drain;
  } ring_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        opcode_i = OP_NOP;
  logic [1:0]        interrupter_i = '0;
  logic [1:0]        segment_i = '0;
  logic [ADDR_W-1:0] base_addr_i = '0;
  logic              trb_cycle_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic              consumed_o;
  logic [ADDR_W-1:0] event_addr_o;
  logic [ADDR_W-1:0] next_addr_o;
  logic [ADDR_W-1:0] dequeue_ptr_value_o;
  logic              cycle_state_o;

  ring_req_t req_q[$];
  res_t      dequeue_q[$];
  int        err_cnt = 0;
  int        run_cycles = 0;
  int        stall_cnt = 0;
  logic      hold_off = 1'b0;
  logic      no_idle = 1'b0;

  logic [ADDR_W-1:0] ring_base [INTRS][SEGS];
  logic [SLOT_W-1:0] ring_slot [INTRS];
  logic [1:0]        ring_seg [INTRS];
  logic              ring_cycle [INTRS];

  int   gen_slot [INTRS];
  logic gen_cyc [INTRS];

  event_ring_dequeue_tracker_top #(
    .ENTRIES_PER_SEGMENT(ENTRIES),
    .SEGMENTS           (SEGS),
    .INTERRUPTERS       (INTRS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .opcode_i           (opcode_i),
    .interrupter_i      (interrupter_i),
    .segment_i          (segment_i),
    .base_addr_i        (base_addr_i),
    .trb_cycle_i        (trb_cycle_i),
    .empty              (empty),
    .pop                (pop),
    .consumed_o         (consumed_o),
    .event_addr_o       (event_addr_o),
    .next_addr_o        (next_addr_o),
    .dequeue_ptr_value_o(dequeue_ptr_value_o),
    .cycle_state_o      (cycle_state_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] slot_addr(input int i);
    return ring_base[i][ring_seg[i]] + (ADDR_W'(ring_slot[i]) << TRB_SHIFT);
  endfunction

  function automatic res_t predict_dequeue(input logic [1:0] op, input logic [1:0] intr,
                                           input logic [1:0] seg, input logic [ADDR_W-1:0] base,
                                           input logic cyc);
    res_t r;
    int   i;
    r = '0;
    i = int'(intr);
    case (op)
      OP_LOAD: begin
        ring_base[i][seg] = base & BASE_MASK;
      end
      OP_RESET: begin
        ring_slot[i] = '0;
        ring_seg[i] = '0;
        ring_cycle[i] = 1'b1;
      end
      OP_CONSUME: begin
        if (cyc == ring_cycle[i]) begin
          r.consumed = 1'b1;
          r.event_addr = slot_addr(i);
          if (ring_slot[i] == SLOT_W'(ENTRIES - 1)) begin
            ring_slot[i] = '0;
            ring_seg[i] = (ring_seg[i] == 2'(SEGS - 1)) ? 2'd0 : ring_seg[i] + 2'd1;
            if (ring_seg[i] == 2'd0) ring_cycle[i] = ~ring_cycle[i];
          end else begin
            ring_slot[i] = ring_slot[i] + 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.next_addr = slot_addr(i);
    r.dequeue_ptr_value = r.consumed ? (r.next_addr | BUSY_FLAG) : '0;
    r.cycle_state = ring_cycle[i];
    return r;
  endfunction

  task automatic add_req(input logic [1:0] op, input logic [1:0] intr, input logic [1:0] seg,
                         input logic [ADDR_W-1:0] base, input logic cyc, input logic drain);
    ring_req_t q;
    int        i;
    i = int'(intr);
    q = '{op: op, intr: intr, seg: seg, base: base, cyc: cyc, drain: drain};
    req_q.push_back(q);
    if (op == OP_RESET) begin
      gen_slot[i] = 0;
      gen_cyc[i] = 1'b1;
    end else if (op == OP_CONSUME && cyc == gen_cyc[i]) begin
      gen_slot[i]++;
      if (gen_slot[i] == ENTRIES * SEGS) begin
        gen_slot[i] = 0;
        gen_cyc[i] = ~gen_cyc[i];
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
    end
  endtask

  // Driver: hold a beat while full, pause for a full drain where a request asks for it.
  always @(posedge clk_i) begin
    logic      offer;
    ring_req_t nxt;
    if (rst_ni) begin
      if (push && !full) begin
        dequeue_q.push_back(predict_dequeue(opcode_i, interrupter_i, segment_i, base_addr_i,
                                            trb_cycle_i));
      end
      if (!push || !full) begin
        offer = req_q.size() != 0;
        if (offer && req_q[0].drain && dequeue_q.size() != 0) offer = 1'b0;
        if (offer && !no_idle && $urandom_range(0, 99) < IDLE_PCT) offer = 1'b0;
        if (offer) begin
          nxt = req_q.pop_front();
          opcode_i <= nxt.op;
          interrupter_i <= nxt.intr;
          segment_i <= nxt.seg;
          base_addr_i <= nxt.base;
          trb_cycle_i <= nxt.cyc;
        end
        push <= offer;
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (dequeue_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got consumed=%b next=%h", $time,
                   consumed_o, next_addr_o);
        end else begin
          want = dequeue_q.pop_front();
          check_field("consumed", ADDR_W'(want.consumed), ADDR_W'(consumed_o));
          check_field("event_addr", want.event_addr, event_addr_o);
          check_field("next_addr", want.next_addr, next_addr_o);
          check_field("dequeue_ptr_value", want.dequeue_ptr_value, dequeue_ptr_value_o);
          check_field("cycle_state", ADDR_W'(want.cycle_state), ADDR_W'(cycle_state_o));
        end
      end
      pop <= !hold_off && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Schedule receiver hold-offs and the idle-free window; watch for a stuck pipe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      run_cycles <= run_cycles + 1;
      hold_off <= (run_cycles >= 300 && run_cycles < 560) ||
                  (run_cycles >= 3000 && run_cycles < 3200);
      no_idle <= run_cycles >= 1200 && run_cycles < 2200;
      if ((push && !full) || (pop && !empty)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
      if (stall_cnt == STALL_LIMIT) begin
        $display("tb_event_ring_dequeue_tracker_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int                r;
    int                intr;
    logic [1:0]        op;
    logic [ADDR_W-1:0] b;
    for (int i = 0; i < INTRS; i++) begin
      ring_slot[i] = '0;
      ring_seg[i] = '0;
      ring_cycle[i] = 1'b1;
      gen_slot[i] = 0;
      gen_cyc[i] = 1'b1;
      for (int s = 0; s < SEGS; s++) ring_base[i][s] = '0;
    end

    // Load every base, segment 0 first, so no access ever hits an unloaded base.
    for (int i = 0; i < INTRS; i++) begin
      for (int s = 0; s < SEGS; s++) begin
        if (i == 0 && s == 0) b = '1;
        else if (i == 0 && s == 1) b = '0;
        else if (i == 1 && s == 0) b = 64'h8000_0000_0000_000F;
        else b = {$urandom, $urandom};
        add_req(OP_LOAD, 2'(i), 2'(s), b, 1'b0, 1'b0);
      end
    end
    add_req(OP_CONSUME, 2'd0, 2'd0, '0, 1'b1, 1'b0);
    add_req(OP_CONSUME, 2'd0, 2'd3, '1, 1'b0, 1'b0);
    add_req(OP_NOP, 2'd1, 2'd2, '1, 1'b1, 1'b0);
    add_req(OP_RESET, 2'd0, 2'd1, '0, 1'b0, 1'b0);
    add_req(OP_CONSUME, 2'd0, 2'd0, '0, 1'b1, 1'b0);
    add_req(OP_CONSUME, 2'd3, 2'd0, '0, 1'b1, 1'b0);
    add_req(OP_LOAD, 2'd2, 2'd3, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
    add_req(OP_CONSUME, 2'd2, 2'd0, '0, 1'b0, 1'b0);

    // Mostly matching consumes on a hot ring so it wraps its segments and flips its cycle bit.
    for (int k = 0; k < N_RANDOM; k++) begin
      intr = (k >= 1500 || $urandom_range(0, 99) >= 90) ? $urandom_range(0, INTRS - 1) : 0;
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_LOAD;
      else if (r < 7) op = OP_NOP;
      else if (r < 9 && (intr != 0 || k >= 1500)) op = OP_RESET;
      else op = OP_CONSUME;
      b = ($urandom_range(0, 9) == 0) ? ~ADDR_W'($urandom_range(0, 15)) : {$urandom, $urandom};
      add_req(op, 2'(intr), 2'($urandom_range(0, SEGS - 1)), b,
              ($urandom_range(0, 99) < 94) ? gen_cyc[intr] : ~gen_cyc[intr],
              k == 0 || k == 900);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || push || dequeue_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_event_ring_dequeue_tracker_top: PASS");
    end else begin
      $display("tb_event_ring_dequeue_tracker_top: FAIL");
    end
    $finish;
  end

endmodule
